// ----- rtl/assert_macros.svh -----
// assertion macros used by the classifier rtl file
// no dependencies; bodies vanish when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/cet_pkg.sv -----
// shared constants and saturating arithmetic for the cubic escape-time block
// no dependencies
package cet_pkg;
	localparam int FRACTION_BITS_DEF = 28;
	localparam int WORD_W = 64;
	localparam int ITER_W = 16;
	localparam int CODE_W = 17;
	localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd100;
	localparam logic signed [WORD_W-1:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [WORD_W-1:0] SAT_MIN = -SAT_MAX;

	typedef logic signed [WORD_W-1:0] word_t;

	function automatic word_t sat_add(input word_t a, input word_t b);
		logic signed [WORD_W:0] s;
		word_t r;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (s > $signed({SAT_MAX[WORD_W-1], SAT_MAX}))
			r = SAT_MAX;
		else if (s < $signed({SAT_MIN[WORD_W-1], SAT_MIN}))
			r = SAT_MIN;
		else
			r = s[WORD_W-1:0];
		return r;
	endfunction

	function automatic word_t sat_sub(input word_t a, input word_t b);
		return sat_add(a, -b);
	endfunction
endpackage

// ----- rtl/cet_mul.sv -----
// sequential saturating fixed-point multiplier, one 32x32 product per cycle while busy
// depends on cet_pkg
module cet_mul import cet_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t op_a,
	input  word_t op_b,
	output logic  done,
	output word_t result
);
	logic [WORD_W-1:0] ma_q, mb_q;
	logic neg_q;
	logic [2*WORD_W-1:0] acc_q;
	logic [2:0] cnt_q;
	logic busy_q;
	logic [31:0] ha, hb;
	logic [63:0] pp;
	logic [2*WORD_W-1:0] pp_sh, shifted;
	logic [WORD_W-1:0] mag_r;
	word_t fin;

	always_comb begin
		ha = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
		hb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
		pp = ha * hb;
		case (cnt_q[1:0])
			2'd0: pp_sh = {64'd0, pp};
			2'd3: pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
		shifted = acc_q >> FRACTION_BITS;
		if (|shifted[2*WORD_W-1:WORD_W-1])
			mag_r = SAT_MAX;
		else
			mag_r = shifted[WORD_W-1:0];
		fin = neg_q ? -word_t'(mag_r) : word_t'(mag_r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 3'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q <= op_a[WORD_W-1] ? 64'(-op_a) : 64'(op_a);
			mb_q <= op_b[WORD_W-1] ? 64'(-op_b) : 64'(op_b);
			neg_q <= op_a[WORD_W-1] ^ op_b[WORD_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4)
				result <= fin;
			else
				acc_q <= acc_q + pp_sh;
		end
	end
endmodule

// ----- rtl/cubic_escape_time_two_critical.sv -----
// Escape-time classifier for the cubic parameter plane. One point takes two bit-serial
// square roots of (32+FRACTION_BITS+1)/2 bits each, then for each of the two critical
// orbits n iterations, where every step runs seven products through one shared
// multiplier (start, four 32x32 partial products, saturation, handshake) plus one
// escape test. The input is stalled until the point finishes; a result waits in an
// output register so the next point can start meanwhile.
`include "assert_macros.svh"
module cubic_escape_time_two_critical import cet_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] param_a,
	input  logic signed [31:0] param_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               both_bounded,
	output logic [CODE_W-1:0]  escape_code
);
	localparam int SW = (32 + FRACTION_BITS + 1) / 2;
	localparam int RAD_W = 2 * SW;
	localparam int REM_W = SW + 3;
	localparam int SC_W = $clog2(SW);
	localparam logic [SC_W-1:0] SQ_LAST = SC_W'(SW - 1);
	localparam word_t LIMIT = 64'sd10 <<< FRACTION_BITS;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQRT = 4'd1;
	localparam logic [3:0] S_ORB  = 4'd2;
	localparam logic [3:0] S_RE2  = 4'd3;
	localparam logic [3:0] S_IM2  = 4'd4;
	localparam logic [3:0] S_TEST = 4'd5;
	localparam logic [3:0] S_P    = 4'd6;
	localparam logic [3:0] S_M1   = 4'd7;
	localparam logic [3:0] S_M2   = 4'd8;
	localparam logic [3:0] S_M3   = 4'd9;
	localparam logic [3:0] S_M4   = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	logic [3:0] state_q;
	logic [ITER_W-1:0] max_iter_q, n_q, i_q;
	logic orbit_q, issued_q, sq_sel_q;
	logic [SC_W-1:0] sq_cnt_q;
	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [SW-1:0] root_q;
	logic b_neg_q, a_neg_q;
	logic [31:0] b_mag_q;
	word_t are_q, aim_q, bre_q, bim_q, a3_q;
	word_t re_q, im_q, re2_q, im2_q, t1_q, t2_q, acc_re_q, acc_im_q;
	logic out_valid_q, both_bounded_q;
	logic [CODE_W-1:0] escape_code_q;

	logic is_mul, mul_start, mul_done;
	word_t mul_a, mul_b, mul_res, mag_sum, t1_next;
	logic [REM_W-1:0] rem_sh, trial;
	logic sq_take;
	logic [SW-1:0] root_next;
	logic in_acc, cfg_wr, escaped, bounded, out_free;
	logic [31:0] a_mag;
	word_t a_ext;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : 32'(max_iter_q);
	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign both_bounded = both_bounded_q;
	assign escape_code = escape_code_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		is_mul = 1'b1;
		mul_a = re_q;
		mul_b = re_q;
		case (state_q)
			S_RE2: begin mul_a = re_q; mul_b = re_q; end
			S_IM2: begin mul_a = im_q; mul_b = im_q; end
			S_P:   begin mul_a = re_q; mul_b = im_q; end
			S_M1:  begin mul_a = t1_q; mul_b = re_q; end
			S_M2:  begin mul_a = t2_q; mul_b = im_q; end
			S_M3:  begin mul_a = t1_q; mul_b = im_q; end
			S_M4:  begin mul_a = t2_q; mul_b = re_q; end
			default: is_mul = 1'b0;
		endcase
		mul_start = is_mul && !issued_q;
	end

	cet_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.op_a(mul_a), .op_b(mul_b), .done(mul_done), .result(mul_res)
	);

	// one root bit per cycle, two radicand bits shifted in
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
		trial = {(REM_W-2)'(root_q), 2'b01};
		sq_take = (rem_sh >= trial);
		root_next = {root_q[SW-2:0], sq_take};
	end

	always_comb begin
		a_mag = param_a[31] ? 32'(-33'(param_a)) : 32'(param_a);
		a_ext = word_t'(param_a);
		mag_sum = sat_add(re2_q, im2_q);
		escaped = (mag_sum >= LIMIT) || (n_q >= max_iter_q);
		t1_next = sat_sub(sat_sub(re2_q, im2_q), a3_q);
		bounded = (i_q >= max_iter_q) && (n_q >= max_iter_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_iter_q <= MAX_ITER_RST;
			issued_q <= 1'b0;
			out_valid_q <= 1'b0;
			sq_cnt_q <= '0;
			sq_sel_q <= 1'b0;
			orbit_q <= 1'b0;
			n_q <= '0;
			i_q <= '0;
		end else begin
			if (cfg_wr)
				max_iter_q <= pwdata[ITER_W-1:0];
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (mul_done)
				issued_q <= 1'b0;
			else if (mul_start)
				issued_q <= 1'b1;
			case (state_q)
				S_IDLE: if (in_acc) begin
					state_q <= S_SQRT;
					sq_cnt_q <= '0;
					sq_sel_q <= 1'b0;
				end
				S_SQRT: begin
					if (sq_cnt_q == SQ_LAST) begin
						sq_cnt_q <= '0;
						sq_sel_q <= 1'b1;
						if (sq_sel_q) begin
							state_q <= S_ORB;
							orbit_q <= 1'b0;
						end
					end else begin
						sq_cnt_q <= sq_cnt_q + 1'b1;
					end
				end
				S_ORB: begin
					n_q <= '0;
					state_q <= S_RE2;
				end
				S_RE2: if (mul_done) state_q <= S_IM2;
				S_IM2: if (mul_done) state_q <= S_TEST;
				S_TEST: begin
					if (escaped) begin
						if (!orbit_q) begin
							i_q <= n_q;
							orbit_q <= 1'b1;
							state_q <= S_ORB;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_P;
					end
				end
				S_P:  if (mul_done) state_q <= S_M1;
				S_M1: if (mul_done) state_q <= S_M2;
				S_M2: if (mul_done) state_q <= S_M3;
				S_M3: if (mul_done) state_q <= S_M4;
				S_M4: if (mul_done) begin
					n_q <= n_q + 1'b1;
					state_q <= S_RE2;
				end
				S_DONE: if (out_free) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_acc) begin
				a3_q <= (a_ext <<< 1) + a_ext;
				a_neg_q <= param_a[31];
				b_neg_q <= param_b[31];
				b_mag_q <= param_b[31] ? 32'(-33'(param_b)) : 32'(param_b);
				rad_q <= RAD_W'(a_mag) << FRACTION_BITS;
				rem_q <= '0;
				root_q <= '0;
			end
			S_SQRT: begin
				if (sq_cnt_q == SQ_LAST) begin
					rad_q <= RAD_W'(b_mag_q) << FRACTION_BITS;
					rem_q <= '0;
					root_q <= '0;
					if (!sq_sel_q) begin
						are_q <= a_neg_q ? '0 : word_t'(root_next);
						aim_q <= a_neg_q ? word_t'(root_next) : '0;
					end else begin
						bre_q <= b_neg_q ? '0 : word_t'(root_next);
						bim_q <= b_neg_q ? word_t'(root_next) : '0;
					end
				end else begin
					rad_q <= rad_q << 2;
					rem_q <= sq_take ? rem_sh - trial : rem_sh;
					root_q <= root_next;
				end
			end
			S_ORB: begin
				re_q <= orbit_q ? -are_q : are_q;
				im_q <= orbit_q ? -aim_q : aim_q;
			end
			S_RE2: if (mul_done) re2_q <= mul_res;
			S_IM2: if (mul_done) im2_q <= mul_res;
			S_TEST: t1_q <= t1_next;
			S_P:  if (mul_done) t2_q <= sat_add(mul_res, mul_res);
			S_M1: if (mul_done) acc_re_q <= mul_res;
			S_M2: if (mul_done) acc_re_q <= sat_sub(acc_re_q, mul_res);
			S_M3: if (mul_done) acc_im_q <= mul_res;
			S_M4: if (mul_done) begin
				re_q <= sat_add(acc_re_q, bre_q);
				im_q <= sat_add(sat_add(acc_im_q, mul_res), bim_q);
			end
			S_DONE: if (out_free) begin
				both_bounded_q <= bounded;
				if (bounded)
					escape_code_q <= '0;
				else if (i_q < n_q)
					escape_code_q <= {n_q, 1'b0};
				else
					escape_code_q <= {i_q, 1'b1};
			end
			default: ;
		endcase
	end

	`ASSERT_NEXT(a_accept_to_sqrt, clk, arst_n, in_acc, state_q == S_SQRT)
	`ASSERT_IMPL(a_bounded_code_zero, clk, arst_n, out_valid_q && both_bounded_q, escape_code_q == '0)
	`ASSERT_IMPL(a_count_in_limit, clk, arst_n, state_q == S_TEST, n_q <= max_iter_q)
endmodule

// ----- tb/cubic_escape_time_two_critical_test.sv -----
// testbench for the cubic escape-time classifier: directed table, iteration-limit corner cases, then random points,
// every beat checked against a typed expectation or an in-bench fixed-point predictor of both critical orbits
// depends on cet_pkg and cubic_escape_time_two_critical
`timescale 1ns / 100ps
`default_nettype none

module cubic_escape_time_two_critical_test;
	import cet_pkg::*;

	localparam int FB = FRACTION_BITS_DEF;
	localparam logic [2:0] REG_MAX_ITER = 3'd0;
	localparam int STALL_LIMIT = 100000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct packed {
		logic               bounded;
		logic [CODE_W-1:0]  code;
	} point_result_t;

	typedef struct {
		logic signed [31:0] a;
		logic signed [31:0] b;
		bit                 typed;
		point_result_t      res;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] param_a = '0, param_b = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic both_bounded;
	logic [CODE_W-1:0] escape_code;

	point_result_t expected_codes[$];
	logic [ITER_W-1:0] iter_limit = MAX_ITER_RST;
	int errors = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	cubic_escape_time_two_critical DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.param_a(param_a), .param_b(param_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.both_bounded(both_bounded), .escape_code(escape_code)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// saturating arithmetic, symmetric bound
	function automatic longint sat_sum(input longint x, input longint y);
		logic signed [64:0] s;
		if (x < SAT_MIN) x = SAT_MIN;
		if (y < SAT_MIN) y = SAT_MIN;
		s = {x[63], x} + {y[63], y};
		if (s > $signed({1'b0, SAT_MAX})) return SAT_MAX;
		if (s < $signed({1'b1, SAT_MIN})) return SAT_MIN;
		return s[63:0];
	endfunction

	function automatic longint sat_diff(input longint x, input longint y);
		if (y < SAT_MIN) y = SAT_MIN;
		return sat_sum(x, -y);
	endfunction

	function automatic longint fix_mul(input longint x, input longint y);
		logic [63:0] mx, my, r;
		logic [127:0] p;
		bit neg;
		neg = (x < 0) != (y < 0);
		mx = (x < 0) ? -x : x;
		my = (y < 0) ? -y : y;
		p = ({64'b0, mx} * {64'b0, my}) >> FB;
		r = (p > {64'b0, SAT_MAX}) ? SAT_MAX : p[63:0];
		return neg ? -r : r;
	endfunction

	function automatic longint fix_sqrt(input logic [63:0] x);
		logic [127:0] t, cc;
		logic [63:0] r, c;
		t = {64'b0, x} << FB;
		r = '0;
		for (int k = 40; k >= 0; k--) begin
			c = r | (64'd1 << k);
			cc = {64'b0, c} * {64'b0, c};
			if (cc <= t) r = c;
		end
		return r;
	endfunction

	function automatic int unsigned orbit_steps(input longint re, input longint im,
		input longint a3, input longint bre, input longint bim);
		longint re2, im2, t1, t2, p, nre, nim;
		longint escape_radius;
		int unsigned n;
		escape_radius = longint'(10) << FB;
		re2 = fix_mul(re, re);
		im2 = fix_mul(im, im);
		n = 0;
		while (n < iter_limit && sat_sum(re2, im2) < escape_radius) begin
			t1 = sat_diff(sat_diff(re2, im2), a3);
			p = fix_mul(re, im);
			t2 = sat_sum(p, p);
			nre = sat_sum(sat_diff(fix_mul(t1, re), fix_mul(t2, im)), bre);
			nim = sat_sum(sat_sum(fix_mul(t1, im), fix_mul(t2, re)), bim);
			re = nre;
			im = nim;
			re2 = fix_mul(re, re);
			im2 = fix_mul(im, im);
			n++;
		end
		return n;
	endfunction

	function automatic point_result_t classify_point(input logic signed [31:0] pa,
		input logic signed [31:0] pb);
		longint av, bv, are, aim, bre, bim;
		int unsigned i, j;
		point_result_t r;
		av = pa;
		bv = pb;
		are = 0; aim = 0; bre = 0; bim = 0;
		if (av >= 0) are = fix_sqrt(av); else aim = fix_sqrt(-av);
		if (bv >= 0) bre = fix_sqrt(bv); else bim = fix_sqrt(-bv);
		i = orbit_steps(are, aim, av * 3, bre, bim);
		j = orbit_steps(-are, -aim, av * 3, bre, bim);
		if (i >= iter_limit && j >= iter_limit) begin
			r.bounded = 1'b1;
			r.code = '0;
		end else begin
			r.bounded = 1'b0;
			r.code = (i < j) ? CODE_W'(j * 2) : CODE_W'(i * 2 + 1);
		end
		return r;
	endfunction

	task automatic wait_drained();
		while (expected_codes.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// setup and access cycle, then read back
	task automatic set_iter_limit(input logic [ITER_W-1:0] lim);
		wait_drained();
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; paddr = REG_MAX_ITER; pwdata = 32'(lim);
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		iter_limit = lim;
		@(negedge clk);
		psel = 1'b1;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata[ITER_W-1:0] !== lim) begin
			errors++;
			if (errors <= 10)
				$display("readback: expected %0d actual %0d", lim, prdata[ITER_W-1:0]);
		end
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
	endtask

	task automatic send_point(input logic signed [31:0] pa, input logic signed [31:0] pb,
		input bit typed, input point_result_t res);
		if (!calm && $urandom_range(99) < 38) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		param_a = pa;
		param_b = pb;
		do @(posedge clk); while (in_stall);
		expected_codes.push_back(typed ? res : classify_point(pa, pb));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic signed [31:0] near_point();
		if ($urandom_range(99) < 70)
			return $signed($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
		return $urandom;
	endfunction

	// receiver stall, with one long hold counted here
	always @(negedge clk) begin
		if (hold_req) begin
			out_stall <= 1'b1;
			hold_req <= 1'b0;
			for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
			out_stall <= 1'b0;
		end else
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 38);
	end

	always @(posedge clk) begin
		point_result_t want;
		if (out_valid && !out_stall) begin
			if (expected_codes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: bounded %0b code %0d", both_bounded, escape_code);
			end else begin
				want = expected_codes.pop_front();
				if (both_bounded !== want.bounded || escape_code !== want.code) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected bounded %0b code %0d, actual %0b %0d",
							want.bounded, want.code, both_bounded, escape_code);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		point_row_t rows[$];
		point_result_t none, bounded0;
		int lims[4];
		int counts[4];
		logic signed [31:0] ra;
		none = '0;
		bounded0 = '{bounded: 1'b1, code: '0};
		lims = '{8, 3, 12, 100};
		counts = '{300, 300, 300, 25};
		rows = '{
			'{32'sh0, 32'sh0, 1, bounded0},
			'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, none},
			'{-32'sh8000_0000, -32'sh8000_0000, 0, none},
			'{32'sh7FFF_FFFF, -32'sh8000_0000, 0, none},
			'{-32'sh8000_0000, 32'sh7FFF_FFFF, 0, none},
			'{32'sh1000_0000, 32'sh0, 0, none},
			'{-32'sh1000_0000, 32'sh0, 0, none},
			'{32'sh0, 32'sh1000_0000, 0, none},
			'{32'sh0, -32'sh1000_0000, 0, none},
			'{32'sh0000_0001, -32'sh0000_0001, 0, none},
			'{32'sh0400_0000, 32'sh0800_0000, 0, none},
			'{-32'sh0800_0000, -32'sh0400_0000, 0, none}
		};

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[k]) send_point(rows[k].a, rows[k].b, rows[k].typed, rows[k].res);

		// zero limit: everything bounded
		set_iter_limit(16'd0);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, bounded0);
		send_point(-32'sh8000_0000, 32'sh0, 1, bounded0);
		set_iter_limit(16'd1);
		send_point(32'sh0, 32'sh0, 1, bounded0);
		send_point(32'sh7FFF_FFFF, 32'sh0, 0, none);
		// top limit only with points whose orbits blow up at once
		set_iter_limit(16'hFFFF);
		for (int k = 0; k < 6; k++) begin
			ra = $urandom_range(32'h7FFF_FFFF, 32'h6000_0000);
			send_point((k % 2) ? -ra : ra, near_point(), 0, none);
		end

		for (int ph = 0; ph < 4; ph++) begin
			set_iter_limit(ITER_W'(lims[ph]));
			for (int k = 0; k < counts[ph]; k++) begin
				if (ph == 0 && k == 50) hold_req = 1'b1;
				if (ph == 1 && k == 100) wait_drained();
				calm = (ph == 1 && k >= 150 && k < 250);
				send_point(near_point(), near_point(), 0, none);
			end
			calm = 1'b0;
		end

		while (expected_codes.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

`default_nettype wire

// ----- cubic_escape_time_two_critical.f -----
+incdir+rtl
rtl/cet_pkg.sv
rtl/cet_mul.sv
rtl/cubic_escape_time_two_critical.sv
tb/cubic_escape_time_two_critical_test.sv
